FILE: hw/rtl/two_queue_page_replacement_unit_macros.svh
// Assertion macros shared by the page replacement unit.
`ifndef TWO_QUEUE_PAGE_REPLACEMENT_UNIT_MACROS_SVH
`define TWO_QUEUE_PAGE_REPLACEMENT_UNIT_MACROS_SVH

// Same-cycle implication checked on every clock edge outside reset.
`define TQPR_CHECK(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("page replacement check failed");

// Next-cycle implication checked on every clock edge outside reset.
`define TQPR_CHECK_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("page replacement check failed");

`endif

FILE: hw/rtl/tqpr_pkg.sv
// Shared types, codes and defaults of the page replacement unit.
package tqpr_pkg;

   localparam int MainEntriesDefault = 16;
   localparam int FifoEntriesDefault = 16;
   localparam int PageBitsDefault    = 31;
   localparam int RspDepth           = 4;
   localparam int CmdDepth           = 2;

   localparam int CFG_WIDTH = 5;

   // Register indexes of the configuration port.
   localparam logic [1:0] CSR_MAIN_CAPACITY      = 2'd0;
   localparam logic [1:0] CSR_PROBATION_CAPACITY = 2'd1;
   localparam logic [1:0] CSR_BYPASS             = 2'd2;

   // Request modes.
   localparam logic [1:0] OP_READ  = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_FLUSH = 2'd2;
   localparam logic [1:0] OP_NONE  = 2'd3;

   // Result kinds.
   localparam logic [1:0] KIND_FETCH      = 2'd0;
   localparam logic [1:0] KIND_WRITE_BACK = 2'd1;
   localparam logic [1:0] KIND_WRITE_THRU = 2'd2;
   localparam logic [1:0] KIND_STATUS     = 2'd3;

   // Status outcomes.
   localparam logic [2:0] OUT_MAIN_HIT = 3'd0;
   localparam logic [2:0] OUT_PROMOTED = 3'd1;
   localparam logic [2:0] OUT_IN_FIFO  = 3'd2;
   localparam logic [2:0] OUT_BYPASSED = 3'd3;
   localparam logic [2:0] OUT_FLUSHED  = 3'd4;

   typedef struct packed {
      logic [CFG_WIDTH-1:0] main_capacity;
      logic [CFG_WIDTH-1:0] probation_capacity;
      logic                 bypass;
   } cfg_type;

   typedef struct packed {
      logic [8:0] main_cnt;
      logic [8:0] fifo_cnt;
      logic       flush_done;
   } stat_type;

endpackage

FILE: hw/rtl/tqpr_front.sv
// Request intake: accepts transactions, drops unused modes, queues commands.
module tqpr_front #(
   parameter int PAGE_BITS = tqpr_pkg::PageBitsDefault
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   output logic                 req_full,
   input  logic [1:0]           req_mode,
   input  logic [PAGE_BITS-1:0] req_page_number,
   output logic                 cmd_valid,
   output logic [1:0]           cmd_op,
   output logic [PAGE_BITS-1:0] cmd_page,
   input  logic                 cmd_pop
);
   import tqpr_pkg::*;

   logic [1:0]           op_ff   [CmdDepth];
   logic [PAGE_BITS-1:0] page_ff [CmdDepth];
   logic                 wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0]           cnt_ff, cnt_in;
   logic                 take, keep;

   assign req_full  = (cnt_ff == 2'(CmdDepth));
   assign take      = req_push && !req_full;
   // Unused mode is accepted but produces no command.
   assign keep      = take && (req_mode != OP_NONE);
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd_op    = op_ff[rd_ff];
   assign cmd_page  = page_ff[rd_ff];

   // Pointer and occupancy update.
   always_comb begin
      wr_in  = keep ? ~wr_ff : wr_ff;
      rd_in  = (cmd_pop && cmd_valid) ? ~rd_ff : rd_ff;
      cnt_in = cnt_ff + 2'(keep) - 2'(cmd_pop && cmd_valid);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // Command storage.
   always_ff @(posedge clock) begin
      if (keep) begin
         op_ff[wr_ff]   <= req_mode;
         page_ff[wr_ff] <= req_page_number;
      end
   end

endmodule

FILE: hw/rtl/tqpr_back.sv
// Policy sequencer holding the LRU main store and the first-seen queue.
module tqpr_back #(
   parameter int MAIN_ENTRIES = tqpr_pkg::MainEntriesDefault,
   parameter int FIFO_ENTRIES = tqpr_pkg::FifoEntriesDefault,
   parameter int PAGE_BITS    = tqpr_pkg::PageBitsDefault
) (
   input  logic                 clock,
   input  logic                 reset,
   input  tqpr_pkg::cfg_type    cfg,
   input  logic                 cmd_valid,
   input  logic [1:0]           cmd_op,
   input  logic [PAGE_BITS-1:0] cmd_page,
   output logic                 cmd_pop,
   input  logic                 out_full,
   output logic                 out_push,
   output logic [1:0]           out_kind,
   output logic [PAGE_BITS-1:0] out_page,
   output logic [2:0]           out_outcome,
   output logic                 out_last,
   output tqpr_pkg::stat_type   stat
);
   import tqpr_pkg::*;

   localparam int MIW = (MAIN_ENTRIES > 1) ? $clog2(MAIN_ENTRIES) : 1;
   localparam int MCW = $clog2(MAIN_ENTRIES + 1);
   localparam int FIW = (FIFO_ENTRIES > 1) ? $clog2(FIFO_ENTRIES) : 1;
   localparam int FCW = $clog2(FIFO_ENTRIES + 1);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_LOOK  = 3'd1;
   localparam logic [2:0] S_ACT   = 3'd2;
   localparam logic [2:0] S_FIFO  = 3'd3;
   localparam logic [2:0] S_PROMO = 3'd4;
   localparam logic [2:0] S_WT    = 3'd5;
   localparam logic [2:0] S_STAT  = 3'd6;
   localparam logic [2:0] S_FLUSH = 3'd7;

   // Both stores are ordered lists: position 0 is most recent or newest.
   logic [PAGE_BITS-1:0] mtag_ff [MAIN_ENTRIES];
   logic [PAGE_BITS-1:0] mtag_in [MAIN_ENTRIES];
   logic                 mdirty_ff [MAIN_ENTRIES];
   logic                 mdirty_in [MAIN_ENTRIES];
   logic [MCW-1:0]       mcnt_ff, mcnt_in;
   logic [PAGE_BITS-1:0] ftag_ff [FIFO_ENTRIES];
   logic [PAGE_BITS-1:0] ftag_in [FIFO_ENTRIES];
   logic [FCW-1:0]       fcnt_ff, fcnt_in;

   logic [2:0]           state_ff, state_in;
   logic [1:0]           op_ff, op_in;
   logic [PAGE_BITS-1:0] page_ff, page_in;
   logic                 mhit_ff, mhit_in, fhit_ff, fhit_in, mfull_ff, mfull_in;
   logic [MIW-1:0]       midx_ff, midx_in, ptr_ff, ptr_in;
   logic [FIW-1:0]       fidx_ff, fidx_in;
   logic [2:0]           outcome_ff, outcome_in;

   logic                 wr, ffull, lookup_mhit, lookup_fhit;
   logic [MIW-1:0]       lookup_midx;
   logic [FIW-1:0]       lookup_fidx;
   logic [MCW-1:0]       lru_w;

   assign wr    = (op_ff == OP_WRITE);
   assign lru_w = mcnt_ff - MCW'(1);

   // Fullness against the capacity register, clamped to the store depth.
   always_comb begin
      ffull = ((fcnt_ff != FCW'(0)) && (32'(fcnt_ff) >= 32'(cfg.probation_capacity)))
              || (32'(fcnt_ff) == 32'(FIFO_ENTRIES));
   end

   // Tag lookup over both stores; the lowest matching position wins.
   always_comb begin
      lookup_mhit = 1'b0;
      lookup_midx = '0;
      for (int i = MAIN_ENTRIES - 1; i >= 0; i--) begin
         if ((32'(i) < 32'(mcnt_ff)) && (mtag_ff[i] == page_ff)) begin
            lookup_mhit = 1'b1;
            lookup_midx = MIW'(i);
         end
      end
      lookup_fhit = 1'b0;
      lookup_fidx = '0;
      for (int i = FIFO_ENTRIES - 1; i >= 0; i--) begin
         if ((32'(i) < 32'(fcnt_ff)) && (ftag_ff[i] == page_ff)) begin
            lookup_fhit = 1'b1;
            lookup_fidx = FIW'(i);
         end
      end
   end

   // Sequencer: one result at most per cycle, held while the result queue is full.
   always_comb begin
      state_in   = state_ff;
      op_in      = op_ff;
      page_in    = page_ff;
      mhit_in    = mhit_ff;
      fhit_in    = fhit_ff;
      midx_in    = midx_ff;
      fidx_in    = fidx_ff;
      ptr_in     = ptr_ff;
      outcome_in = outcome_ff;
      mcnt_in    = mcnt_ff;
      fcnt_in    = fcnt_ff;
      mtag_in    = mtag_ff;
      mdirty_in  = mdirty_ff;
      ftag_in    = ftag_ff;
      mfull_in   = mfull_ff;
      cmd_pop    = 1'b0;
      out_push   = 1'b0;
      out_kind   = KIND_STATUS;
      out_page   = page_ff;
      out_outcome = 3'd0;
      out_last   = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               cmd_pop  = 1'b1;
               op_in    = cmd_op;
               page_in  = cmd_page;
               state_in = S_LOOK;
            end
         end
         S_LOOK: begin
            mhit_in  = lookup_mhit;
            midx_in  = lookup_midx;
            fhit_in  = lookup_fhit;
            fidx_in  = lookup_fidx;
            mfull_in = ((mcnt_ff != MCW'(0)) &&
                        (32'(mcnt_ff) >= 32'(cfg.main_capacity)))
                       || (32'(mcnt_ff) == 32'(MAIN_ENTRIES));
            if (op_ff == OP_FLUSH) begin
               outcome_in = OUT_FLUSHED;
               page_in    = '0;
               if (mcnt_ff == MCW'(0)) begin
                  state_in = S_STAT;
               end else begin
                  ptr_in   = lru_w[MIW-1:0];
                  state_in = S_FLUSH;
               end
            end else begin
               state_in = S_ACT;
            end
         end
         default: begin
            if (!out_full) begin
               case (state_ff)
                  S_ACT: begin
                     if (wr && cfg.bypass) begin
                        out_push   = 1'b1;
                        out_kind   = KIND_WRITE_THRU;
                        outcome_in = OUT_BYPASSED;
                        state_in   = S_STAT;
                     end else if (mhit_ff) begin
                        // Move the hit entry to the front.
                        for (int i = 1; i < MAIN_ENTRIES; i++) begin
                           if (i <= int'(midx_ff)) begin
                              mtag_in[i]   = mtag_ff[i-1];
                              mdirty_in[i] = mdirty_ff[i-1];
                           end
                        end
                        mtag_in[0]   = mtag_ff[midx_ff];
                        mdirty_in[0] = mdirty_ff[midx_ff] | wr;
                        outcome_in   = OUT_MAIN_HIT;
                        state_in     = S_STAT;
                     end else if (!wr) begin
                        out_push = 1'b1;
                        out_kind = KIND_FETCH;
                        if (cfg.bypass) begin
                           outcome_in = OUT_BYPASSED;
                           state_in   = S_STAT;
                        end else begin
                           state_in = S_FIFO;
                        end
                     end else begin
                        state_in = S_FIFO;
                     end
                  end
                  S_FIFO: begin
                     if (fhit_ff) begin
                        if (mfull_ff) begin
                           // Evict the least recent page.
                           if (mdirty_ff[lru_w[MIW-1:0]]) begin
                              out_push = 1'b1;
                              out_kind = KIND_WRITE_BACK;
                              out_page = mtag_ff[lru_w[MIW-1:0]];
                           end
                           mcnt_in = lru_w;
                        end
                        state_in = S_PROMO;
                     end else begin
                        // Enter the first-seen queue, dropping the oldest when full.
                        for (int i = 1; i < FIFO_ENTRIES; i++) begin
                           ftag_in[i] = ftag_ff[i-1];
                        end
                        ftag_in[0] = page_ff;
                        if (!ffull) begin
                           fcnt_in = fcnt_ff + FCW'(1);
                        end
                        outcome_in = OUT_IN_FIFO;
                        state_in   = wr ? S_WT : S_STAT;
                     end
                  end
                  S_PROMO: begin
                     for (int i = 0; i < FIFO_ENTRIES - 1; i++) begin
                        if (i >= int'(fidx_ff)) begin
                           ftag_in[i] = ftag_ff[i+1];
                        end
                     end
                     fcnt_in = fcnt_ff - FCW'(1);
                     for (int i = 1; i < MAIN_ENTRIES; i++) begin
                        mtag_in[i]   = mtag_ff[i-1];
                        mdirty_in[i] = mdirty_ff[i-1];
                     end
                     mtag_in[0]   = page_ff;
                     mdirty_in[0] = wr;
                     mcnt_in      = mcnt_ff + MCW'(1);
                     outcome_in   = OUT_PROMOTED;
                     state_in     = S_STAT;
                  end
                  S_WT: begin
                     out_push = 1'b1;
                     out_kind = KIND_WRITE_THRU;
                     state_in = S_STAT;
                  end
                  S_FLUSH: begin
                     // Walk from least to most recent, writing back dirty pages.
                     if (mdirty_ff[ptr_ff]) begin
                        out_push = 1'b1;
                        out_kind = KIND_WRITE_BACK;
                        out_page = mtag_ff[ptr_ff];
                     end
                     if (ptr_ff == MIW'(0)) begin
                        mcnt_in  = '0;
                        state_in = S_STAT;
                     end else begin
                        ptr_in = ptr_ff - MIW'(1);
                     end
                  end
                  S_STAT: begin
                     out_push    = 1'b1;
                     out_kind    = KIND_STATUS;
                     out_outcome = outcome_ff;
                     out_last    = 1'b1;
                     state_in    = S_IDLE;
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         mcnt_ff  <= '0;
         fcnt_ff  <= '0;
      end else begin
         state_ff <= state_in;
         mcnt_ff  <= mcnt_in;
         fcnt_ff  <= fcnt_in;
      end
   end

   // Payload and store registers.
   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      page_ff    <= page_in;
      mhit_ff    <= mhit_in;
      fhit_ff    <= fhit_in;
      midx_ff    <= midx_in;
      fidx_ff    <= fidx_in;
      ptr_ff     <= ptr_in;
      mfull_ff   <= mfull_in;
      outcome_ff <= outcome_in;
      mtag_ff    <= mtag_in;
      mdirty_ff  <= mdirty_in;
      ftag_ff    <= ftag_in;
   end

   assign stat.main_cnt   = 9'(mcnt_ff);
   assign stat.fifo_cnt   = 9'(fcnt_ff);
   assign stat.flush_done = out_push && out_last && (out_outcome == OUT_FLUSHED);

endmodule

FILE: hw/rtl/tqpr_rsp_fifo.sv
// Result queue between the sequencer and the result ports.
module tqpr_rsp_fifo #(
   parameter int PAGE_BITS = tqpr_pkg::PageBitsDefault
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_push,
   output logic                 in_full,
   input  logic [1:0]           in_kind,
   input  logic [PAGE_BITS-1:0] in_page,
   input  logic [2:0]           in_outcome,
   input  logic                 in_last,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output logic [1:0]           rsp_kind,
   output logic [PAGE_BITS-1:0] rsp_target_page,
   output logic [2:0]           rsp_outcome,
   output logic                 rsp_last
);
   import tqpr_pkg::*;

   localparam int DW = PAGE_BITS + 6;
   localparam int AW = $clog2(RspDepth);

   logic [DW-1:0] data_ff [RspDepth];
   logic [AW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [AW:0]   cnt_ff, cnt_in;
   logic          wen, ren;

   assign in_full   = (cnt_ff == (AW+1)'(RspDepth));
   assign rsp_empty = (cnt_ff == '0);
   assign wen       = in_push && !in_full;
   assign ren       = rsp_pop && !rsp_empty;
   assign {rsp_kind, rsp_target_page, rsp_outcome, rsp_last} = data_ff[rd_ff];

   // Pointer and occupancy update.
   always_comb begin
      wr_in  = wen ? wr_ff + AW'(1) : wr_ff;
      rd_in  = ren ? rd_ff + AW'(1) : rd_ff;
      cnt_in = cnt_ff + (AW+1)'(wen) - (AW+1)'(ren);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // Result storage.
   always_ff @(posedge clock) begin
      if (wen) begin
         data_ff[wr_ff] <= {in_kind, in_page, in_outcome, in_last};
      end
   end

endmodule

FILE: hw/rtl/two_queue_page_replacement_unit.sv
// Top level of the two-queue page replacement unit.
// A request transaction goes through a two-entry command queue into a policy sequencer,
// which takes the command, does the tag lookup over both stores, then runs two to four
// policy steps (access action, first-seen queue step, promotion or write through, status),
// each giving at most one result transaction. A flush walks the main store, one step per
// page, from least to most recent, and ends with its status. Results wait in a four-entry
// queue; the sequencer holds while that queue is full. Unused mode 3 is accepted and yields
// nothing.
module two_queue_page_replacement_unit #(
   parameter int MAIN_ENTRIES = tqpr_pkg::MainEntriesDefault,
   parameter int FIFO_ENTRIES = tqpr_pkg::FifoEntriesDefault,
   parameter int PAGE_BITS    = tqpr_pkg::PageBitsDefault
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_push,
   output logic                           req_full,
   input  logic [1:0]                     req_mode,
   input  logic [PAGE_BITS-1:0]           req_page_number,
   output logic                           rsp_empty,
   input  logic                           rsp_pop,
   output logic [1:0]                     rsp_kind,
   output logic [PAGE_BITS-1:0]           rsp_target_page,
   output logic [2:0]                     rsp_outcome,
   output logic                           rsp_last,
   input  logic                           csr_write_enable,
   input  logic [1:0]                     csr_index,
   input  logic [tqpr_pkg::CFG_WIDTH-1:0] csr_wdata
);
   import tqpr_pkg::*;

   `include "two_queue_page_replacement_unit_macros.svh"

   cfg_type              cfg_ff, cfg_in;
   stat_type             stat;
   logic                 cmd_valid, cmd_pop, out_full, out_push, out_last;
   logic [1:0]           cmd_op, out_kind;
   logic [PAGE_BITS-1:0] cmd_page, out_page;
   logic [2:0]           out_outcome;

   // Configuration registers.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_MAIN_CAPACITY:      cfg_in.main_capacity      = csr_wdata;
            CSR_PROBATION_CAPACITY: cfg_in.probation_capacity = csr_wdata;
            CSR_BYPASS:             cfg_in.bypass             = csr_wdata[0];
            default:                cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.main_capacity      <= CFG_WIDTH'(16);
         cfg_ff.probation_capacity <= CFG_WIDTH'(8);
         cfg_ff.bypass             <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   tqpr_front #(.PAGE_BITS(PAGE_BITS)) u_front (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full),
      .req_mode(req_mode), .req_page_number(req_page_number),
      .cmd_valid(cmd_valid), .cmd_op(cmd_op), .cmd_page(cmd_page), .cmd_pop(cmd_pop)
   );

   tqpr_back #(
      .MAIN_ENTRIES(MAIN_ENTRIES), .FIFO_ENTRIES(FIFO_ENTRIES), .PAGE_BITS(PAGE_BITS)
   ) u_back (
      .clock(clock), .reset(reset), .cfg(cfg_ff),
      .cmd_valid(cmd_valid), .cmd_op(cmd_op), .cmd_page(cmd_page), .cmd_pop(cmd_pop),
      .out_full(out_full), .out_push(out_push), .out_kind(out_kind), .out_page(out_page),
      .out_outcome(out_outcome), .out_last(out_last), .stat(stat)
   );

   tqpr_rsp_fifo #(.PAGE_BITS(PAGE_BITS)) u_rsp (
      .clock(clock), .reset(reset),
      .in_push(out_push), .in_full(out_full), .in_kind(out_kind), .in_page(out_page),
      .in_outcome(out_outcome), .in_last(out_last),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_kind(rsp_kind),
      .rsp_target_page(rsp_target_page), .rsp_outcome(rsp_outcome), .rsp_last(rsp_last)
   );

   // Occupancy stays within the stores, and a flush leaves the main store empty.
   `TQPR_CHECK(main_cnt_bound, 1'b1, stat.main_cnt <= 9'(MAIN_ENTRIES))
   `TQPR_CHECK(fifo_cnt_bound, 1'b1, stat.fifo_cnt <= 9'(FIFO_ENTRIES))
   `TQPR_CHECK_NEXT(flush_empties_main, stat.flush_done, stat.main_cnt == 9'd0)

endmodule
